// ===== hdl/arpc_pkg.sv =====
`timescale 1ns / 1ps

package arpc_pkg;

    // Default sizing
    localparam int TABLE_ENTRIES_DEF    = 4;
    localparam int CPUS_PER_CHIPLET_DEF = 8;

    // Field widths
    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int MASK_W     = 8;
    localparam int CHIPLETS   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int CNT_CFG_W  = 3;

    // Largest well-formed coherence kind
    localparam logic [2:0] KIND_MAX = 3'd4;

    // Verdict codes
    localparam logic [1:0] VERDICT_ALLOW     = 2'd0;
    localparam logic [1:0] VERDICT_DENY      = 2'd1;
    localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd1;

    // One region table entry
    typedef struct packed {
        logic [PAGE_W-1:0] start_page;
        logic [PAGE_W-1:0] end_page;
        logic [MASK_W-1:0] mask;
    } region_entry_t;

    // Finished check result
    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] slot;
    } scan_res_t;

endpackage

// ===== hdl/arpc_region_table.sv =====
`timescale 1ns / 1ps

module arpc_region_table
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W         = 2
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  region_entry_t        wr_entry,
    input  logic [IDX_W-1:0]     rd_idx,
    output region_entry_t        rd_entry
);

    region_entry_t mem [TABLE_ENTRIES];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        rd_entry <= mem[rd_idx];
    end

endmodule

// ===== hdl/arpc_scan.sv =====
`timescale 1ns / 1ps

module arpc_scan
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF,
    parameter int CPUS_PER_CHIPLET = CPUS_PER_CHIPLET_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 req_type,
    input  logic [1:0]           entry_slot,
    input  logic [PAGE_W-1:0]    entry_start_page,
    input  logic [PAGE_W-1:0]    entry_end_page,
    input  logic [MASK_W-1:0]    entry_mask,
    input  logic                 is_credit,
    input  logic                 is_request,
    input  logic [2:0]           coherence_kind,
    input  logic [7:0]           requester_id,
    input  logic [ADDR_W-1:0]    access_address,
    input  logic                 check_enable,
    input  logic [CNT_CFG_W-1:0] entries_in_use,
    output logic                 res_valid,
    input  logic                 res_take,
    output scan_res_t            res
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = ((IDX_W > CNT_CFG_W) ? IDX_W : CNT_CFG_W) + 1;
    localparam int RID_W = 10;
    localparam logic [2:0] NO_SLOT = 3'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [2:0]          chiplet_reg, chiplet_next;
    logic                chip_ok_reg, chip_ok_next;
    scan_res_t           res_reg, res_next;

    logic                accept;
    logic                slot_ok;
    logic                wr_en;
    logic [CW-1:0]       n_clamp;
    logic [CW-1:0]       idx_inc;
    logic [IDX_W-1:0]    rd_idx;
    region_entry_t       wr_entry;
    region_entry_t       rd_entry;
    logic                hit;
    logic                decide;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

    // Table write on an accepted write request within the table
    assign slot_ok  = CW'(entry_slot) < CW'(TABLE_ENTRIES);
    assign wr_en    = accept && req_type && slot_ok;
    assign wr_entry = '{start_page: entry_start_page,
                        end_page:   entry_end_page,
                        mask:       entry_mask};

    // Clamp scan length to the table size
    assign n_clamp = (CW'(entries_in_use) > CW'(TABLE_ENTRIES)) ?
                     CW'(TABLE_ENTRIES) : CW'(entries_in_use);

    // Next entry to fetch
    assign idx_inc = CW'(idx_reg) + CW'(1);
    always_comb
    begin
        if (state_reg == S_SCAN && idx_inc < CW'(TABLE_ENTRIES))
        begin
            rd_idx = IDX_W'(idx_inc);
        end
        else
        begin
            rd_idx = '0;
        end
    end

    arpc_region_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (IDX_W'(entry_slot)),
        .wr_entry (wr_entry),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry)
    );

    // Chiplet number: count the chiplet boundaries at or below the requester
    always_comb
    begin
        chiplet_next = '0;
        for (int k = 1; k < CHIPLETS; k++)
        begin
            if (RID_W'(requester_id) >= RID_W'(k * CPUS_PER_CHIPLET))
            begin
                chiplet_next = chiplet_next + 3'd1;
            end
        end
        chip_ok_next = RID_W'(requester_id) < RID_W'(CHIPLETS * CPUS_PER_CHIPLET);
    end

    // Shared compare unit: page range and chiplet check
    assign hit    = (page_reg >= rd_entry.start_page) && (page_reg <= rd_entry.end_page);
    assign decide = hit && chip_ok_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        page_next  = page_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    page_next = access_address[ADDR_W-1:PAGE_SHIFT];
                    n_next    = n_clamp;
                    idx_next  = '0;
                    res_next  = '{verdict: VERDICT_ALLOW, slot: NO_SLOT};
                    state_next = S_DONE;
                    if (req_type)
                    begin
                        res_next.verdict = VERDICT_ALLOW;
                    end
                    else if (!check_enable || is_credit || !is_request)
                    begin
                        res_next.verdict = VERDICT_ALLOW;
                    end
                    else if (coherence_kind > KIND_MAX)
                    begin
                        res_next.verdict = VERDICT_MALFORMED;
                    end
                    else if (n_clamp == '0)
                    begin
                        res_next.verdict = VERDICT_DENY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (decide)
                begin
                    res_next.verdict = rd_entry.mask[chiplet_reg] ? VERDICT_ALLOW
                                                                  : VERDICT_DENY;
                    res_next.slot    = 3'(idx_reg);
                    state_next       = S_DONE;
                end
                else if (idx_inc == n_reg)
                begin
                    res_next.verdict = VERDICT_DENY;
                    res_next.slot    = NO_SLOT;
                    state_next       = S_DONE;
                end
                else
                begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            n_reg       <= '0;
            page_reg    <= '0;
            chiplet_reg <= '0;
            chip_ok_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            page_reg  <= page_next;
            res_reg   <= res_next;
            if (accept)
            begin
                chiplet_reg <= chiplet_next;
                chip_ok_reg <= chip_ok_next;
            end
        end
    end

endmodule

// ===== hdl/address_range_permission_check_top.sv =====
`timescale 1ns / 1ps

// Access permission checker for flits crossing a link. A write request
// (req_type 1) loads one region table entry; a check request returns
// allowed, denied or malformed together with the slot that decided it.
// Checks that reach the scan step through the region table one entry
// per cycle through a single range comparator, comparing at most
// entries_in_use entries; table writes, passed flits and malformed
// requests do not scan. The result sits in an output register,
// so a new request is taken while an earlier result waits on result_ready.
// Table entries hold no value until written; the user must see that
// configuration is written only while no request is in flight; the
// block itself does not enforce this.
module address_range_permission_check_top
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF,
    parameter int CPUS_PER_CHIPLET = CPUS_PER_CHIPLET_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  req_type,
    input  logic [1:0]            entry_slot,
    input  logic [PAGE_W-1:0]     entry_start_page,
    input  logic [PAGE_W-1:0]     entry_end_page,
    input  logic [MASK_W-1:0]     entry_mask,
    input  logic                  is_credit,
    input  logic                  is_request,
    input  logic [2:0]            coherence_kind,
    input  logic [7:0]            requester_id,
    input  logic [ADDR_W-1:0]     access_address,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [1:0]            verdict,
    output logic [2:0]            matched_slot
);

    logic                 check_enable_reg;
    logic [CNT_CFG_W-1:0] entries_in_use_reg;
    logic                 out_valid_reg;
    scan_res_t            out_reg;
    logic                 res_valid;
    logic                 res_take;
    scan_res_t            res;

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign verdict      = out_reg.verdict;
    assign matched_slot = out_reg.slot;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg   <= 1'b0;
            entries_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CHECK_ENABLE:   check_enable_reg   <= cfg_data[0];
                CFG_ENTRIES_IN_USE: entries_in_use_reg <= cfg_data[CNT_CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    arpc_scan #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .CPUS_PER_CHIPLET (CPUS_PER_CHIPLET)
    ) u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .req_type         (req_type),
        .entry_slot       (entry_slot),
        .entry_start_page (entry_start_page),
        .entry_end_page   (entry_end_page),
        .entry_mask       (entry_mask),
        .is_credit        (is_credit),
        .is_request       (is_request),
        .coherence_kind   (coherence_kind),
        .requester_id     (requester_id),
        .access_address   (access_address),
        .check_enable     (check_enable_reg),
        .entries_in_use   (entries_in_use_reg),
        .res_valid        (res_valid),
        .res_take         (res_take),
        .res              (res)
    );

    // Move a finished result into the output register when it is free
    assign res_take = res_valid && (!out_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
